[sv/idle_timeout_frame_crc_checker_defines.svh]
// Assertion helpers used by the checker file itfcc_checker.sv.
`ifndef IDLE_TIMEOUT_FRAME_CRC_CHECKER_DEFINES_SVH
`define IDLE_TIMEOUT_FRAME_CRC_CHECKER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ITFCC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication guarded by a qualifier signal.
`define ITFCC_ASSERT_WHEN(label, clk, rstn, qual, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (qual) |-> (prop)) \
        else $error(msg);

`endif

[sv/itfcc_pkg.sv]
package itfcc_pkg;

    localparam int COUNT_W          = 9;
    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 16;

    localparam logic [7:0]         FRAME_HEADER = 8'h5A;
    localparam logic [COUNT_W-1:0] MIN_FRAME    = 9'd4;
    localparam logic [15:0]        CRC_INIT     = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY     = 16'hA001;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               header_ok;
        logic               length_ok;
        logic               crc_ok;
        logic               frame_good;
        logic [COUNT_W-1:0] frame_bytes;
    } result_t;

    // Modbus CRC-16, one byte, reflected polynomial
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[sv/idle_timeout_frame_crc_checker.sv]
// Frame checker for a byte stream closed by an idle timeout, with Modbus CRC-16.
// Input channel s_axis: one transaction per received byte (tuser = 0, byte in
// tdata) or per timer tick (tuser = 1, tdata ignored). Bytes build up a frame:
// header, length L, L payload bytes, then CRC low and high byte.
// Output channel m_axis: one transaction per closed frame, issued when a tick
// sees the byte count unchanged since the previous tick and above four.
// A closing tick's result passes through the input register, then the result
// register, on its way to m_axis. Throughput: one transaction per cycle while
// s_axis_tready is high; the byte-wide CRC update is a single unrolled step
// between the input register and the CRC register.
// Reset (aresetn low, synchronous) empties both registers, clears the byte
// count and loads the CRC with 0xFFFF.
// When m_axis stalls, the result register holds; the input register still
// drains bytes and non-closing ticks, and s_axis_tready drops only when a
// closing tick waits behind a result that has not been taken.
module idle_timeout_frame_crc_checker import itfcc_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic                   s_axis_tuser,  // [0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] header_ok, [1] length_ok, [2] crc_ok, [3] frame_good,
    // [12:4] frame_bytes, [15:13] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [7:0] in_byte_reg;

    logic    advance;
    logic    close;
    logic    can_load;
    result_t result;

    // a closing tick needs room in the result register; everything else passes
    assign advance       = in_valid_reg && (can_load || !close);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
    end

    itfcc_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cmd     (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .close   (close),
        .result  (result)
    );

    itfcc_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && close),
        .load_data     (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[sv/itfcc_core.sv]
module itfcc_core import itfcc_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  cmd_t    cmd,
    input  logic [7:0] rx_byte,
    output logic    close,
    output result_t result
);

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(BUFFER_DEPTH);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] last_count_reg, last_count_next;
    logic [7:0]         first_byte_reg, first_byte_next;
    logic [7:0]         length_byte_reg, length_byte_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        rx_crc_reg, rx_crc_next;

    logic [COUNT_W:0]   pos_ext;
    logic [COUNT_W:0]   crc_end;
    logic [COUNT_W:0]   min_len;
    logic [15:0]        crc_upd;
    logic               len_ok;

    assign pos_ext = {1'b0, byte_count_reg};
    assign crc_end = {2'b00, length_byte_reg} + 10'd2;
    assign min_len = {2'b00, length_byte_reg} + 10'd4;
    assign crc_upd = crc_add_byte((byte_count_reg == '0) ? CRC_INIT : crc_reg, rx_byte);
    assign len_ok  = pos_ext >= min_len;

    assign close = (cmd == CMD_TICK) && (byte_count_reg == last_count_reg)
                   && (byte_count_reg > MIN_FRAME);

    always_comb begin
        result.header_ok   = (first_byte_reg == FRAME_HEADER);
        result.length_ok   = len_ok;
        result.crc_ok      = len_ok && (crc_reg == rx_crc_reg);
        result.frame_good  = result.header_ok && result.length_ok && result.crc_ok;
        result.frame_bytes = byte_count_reg;
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        last_count_next  = last_count_reg;
        first_byte_next  = first_byte_reg;
        length_byte_next = length_byte_reg;
        crc_next         = crc_reg;
        rx_crc_next      = rx_crc_reg;
        if (cmd == CMD_BYTE) begin
            if (byte_count_reg >= DEPTH_C) begin
                // store full: drop the byte and restart counting
                byte_count_next = '0;
            end else begin
                if (byte_count_reg == '0) begin
                    first_byte_next = rx_byte;
                    crc_next        = crc_upd;
                    rx_crc_next     = '0;
                end else if (byte_count_reg == COUNT_W'(1)) begin
                    length_byte_next = rx_byte;
                    crc_next         = crc_upd;
                end else if (pos_ext < crc_end) begin
                    crc_next = crc_upd;
                end else if (pos_ext == crc_end) begin
                    rx_crc_next[7:0] = rx_byte;
                end else if (pos_ext == crc_end + 10'd1) begin
                    rx_crc_next[15:8] = rx_byte;
                end
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end
        end else begin
            byte_count_next = close ? '0 : byte_count_reg;
            last_count_next = close ? '0 : byte_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            last_count_reg  <= '0;
            first_byte_reg  <= '0;
            length_byte_reg <= '0;
            crc_reg         <= CRC_INIT;
            rx_crc_reg      <= '0;
        end else if (advance) begin
            byte_count_reg  <= byte_count_next;
            last_count_reg  <= last_count_next;
            first_byte_reg  <= first_byte_next;
            length_byte_reg <= length_byte_next;
            crc_reg         <= crc_next;
            rx_crc_reg      <= rx_crc_next;
        end
    end

endmodule

[sv/itfcc_out_reg.sv]
module itfcc_out_reg import itfcc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                load_data,
    output logic                   can_load,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - COUNT_W - 4){1'b0}}, data_reg.frame_bytes,
                            data_reg.frame_good, data_reg.crc_ok, data_reg.length_ok,
                            data_reg.header_ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

[sv/itfcc_checker.sv]
`include "idle_timeout_frame_crc_checker_defines.svh"

module itfcc_checker import itfcc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // hold a stalled result
    `ITFCC_ASSERT_WHEN(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
    // frame_good is the and of the three checks
    `ITFCC_ASSERT_WHEN(a_good_and, aclk, aresetn, m_axis_tvalid, m_axis_tdata[3] == (m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[2]), "frame_good mismatch")
    // a CRC match is only reported on a frame that is long enough
    `ITFCC_ASSERT_WHEN(a_crc_len, aclk, aresetn, m_axis_tvalid, !m_axis_tdata[2] || m_axis_tdata[1], "crc_ok without length_ok")
    // a result only follows an accepted tick, and only for frames above four bytes
    `ITFCC_ASSERT_WHEN(a_new_result, aclk, aresetn, $rose(m_axis_tvalid), $past(in_xfer, 2) && $past(s_axis_tuser, 2) && (m_axis_tdata[12:4] > 9'd4), "result without a closing tick")

endmodule

bind idle_timeout_frame_crc_checker itfcc_checker u_itfcc_checker (.*);
